// ===== hw/rtl/arc_pose_update_unit_assert.svh =====
// Assertion macros for the arc pose update unit
`ifndef ARC_POSE_UPDATE_UNIT_ASSERT_SVH
`define ARC_POSE_UPDATE_UNIT_ASSERT_SVH

// Check a condition in the same cycle as its trigger
`define APU_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("apu: same-cycle check failed");

// Check a condition in the cycle after its trigger
`define APU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("apu: next-cycle check failed");

`endif

// ===== hw/rtl/apu_pkg.sv =====
// Package for the arc pose update unit: types, constants and CORDIC helpers
`default_nettype none
package apu_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ANGLE_BITS_DEF = 16;
	localparam int ANGLE_BITS_MAX = 24;
	localparam int ATAN_ENTRIES = 24;
	localparam int CW = 34;
	localparam int ZW = ANGLE_BITS_MAX + 2;
	localparam int DIV_BITS = 31;
	localparam logic [29:0] RAD_K = 30'd683565276;
	localparam logic signed [CW-1:0] INV_GAIN = CW'(652032875);

	typedef enum logic [1:0] {
		QUAD_0,
		QUAD_90,
		QUAD_180,
		QUAD_270
	} apu_quad_t;

	typedef struct packed {
		logic signed [31:0]   px;
		logic signed [31:0]   py;
		logic signed [23:0]   len;
		logic [15:0]          nh;
		logic                 arc;
		logic                 rsat;
		logic [15:0]          adh;
		logic [36:0]          num;
		logic [15:0]          rem;
		logic [30:0]          quo;
		apu_quad_t            qa;
		apu_quad_t            qb;
		logic signed [CW-1:0] xa;
		logic signed [CW-1:0] ya;
		logic signed [ZW-1:0] za;
		logic signed [CW-1:0] xb;
		logic signed [CW-1:0] yb;
		logic signed [ZW-1:0] zb;
	} apu_iter_t;

	// Arctangent of 2^-i as a fraction of a turn, 2^32 per turn
	function automatic logic [31:0] atan_turn(int i);
		case (i)
			0:  return 32'h20000000;
			1:  return 32'h12E4051E;
			2:  return 32'h09FB385B;
			3:  return 32'h051111D4;
			4:  return 32'h028B0D43;
			5:  return 32'h0145D7E1;
			6:  return 32'h00A2F61E;
			7:  return 32'h00517C55;
			8:  return 32'h0028BE53;
			9:  return 32'h00145F2F;
			10: return 32'h000A2F98;
			11: return 32'h000517CC;
			12: return 32'h00028BE6;
			13: return 32'h000145F3;
			14: return 32'h0000A2FA;
			15: return 32'h0000517D;
			16: return 32'h000028BE;
			17: return 32'h0000145F;
			18: return 32'h00000A30;
			19: return 32'h00000518;
			20: return 32'h0000028C;
			21: return 32'h00000146;
			22: return 32'h000000A3;
			23: return 32'h00000051;
			default: return 32'h00000000;
		endcase
	endfunction

	// Arctangent step rounded to ab bits per turn
	function automatic logic signed [ZW-1:0] atan_step(int i, int ab);
		logic [32:0] s;
		s = {1'b0, atan_turn(i)} + (33'd1 << (31 - ab));
		s = s >> (32 - ab);
		return $signed(s[ZW-1:0]);
	endfunction

	// Scale a 16-bit angle to ab bits per turn
	function automatic logic [31:0] scale_ang(logic [15:0] ang, int ab);
		logic [31:0] a;
		if (ab >= 16) begin
			a = {16'd0, ang} << (ab - 16);
		end else begin
			a = {16'd0, ang} >> (16 - ab);
		end
		return a & ((32'd1 << ab) - 32'd1);
	endfunction

	function automatic apu_quad_t quad_of(logic [15:0] ang, int ab);
		logic [31:0] a;
		a = scale_ang(ang, ab);
		return apu_quad_t'(2'((a + (32'd1 << (ab - 3))) >> (ab - 2)));
	endfunction

	// Residual angle after quadrant removal, signed
	function automatic logic signed [ZW-1:0] zres_of(logic [15:0] ang, int ab);
		logic [31:0] a;
		logic [31:0] z;
		logic [1:0]  q;
		a = scale_ang(ang, ab);
		q = 2'((a + (32'd1 << (ab - 3))) >> (ab - 2));
		z = (a - ({30'd0, q} << (ab - 2))) & ((32'd1 << ab) - 32'd1);
		if (z >= (32'd1 << (ab - 1))) begin
			z = z - (32'd1 << ab);
		end
		return $signed(z[ZW-1:0]);
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/apu_iter_stage.sv =====
// One pipeline stage: radius division step and/or CORDIC rotation step for both angles
`default_nettype none
module apu_iter_stage #(
	parameter int IDX = 0,
	parameter int CORDIC_STAGES = apu_pkg::CORDIC_STAGES_DEF,
	parameter int ANGLE_BITS = apu_pkg::ANGLE_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  apu_pkg::apu_iter_t     in_data,
	output logic                   out_valid,
	output apu_pkg::apu_iter_t     out_data
);
	import apu_pkg::*;

	localparam bit DO_DIV = (IDX < DIV_BITS);
	localparam bit DO_ROT = (IDX < CORDIC_STAGES) && (IDX < ATAN_ENTRIES);
	localparam int BIT = DO_DIV ? (DIV_BITS - 1 - IDX) : 0;
	localparam logic signed [ZW-1:0] STEP = atan_step(IDX, ANGLE_BITS);

	apu_iter_t   nxt;
	logic [16:0] trial;
	logic        vld_s1;
	apu_iter_t   data_s1;

	always_comb begin
		nxt = in_data;
		trial = {in_data.rem, in_data.num[BIT]};
		if (DO_DIV) begin
			// restoring step: one quotient bit
			if (trial >= {1'b0, in_data.adh}) begin
				nxt.rem = 16'(trial - {1'b0, in_data.adh});
				nxt.quo = {in_data.quo[29:0], 1'b1};
			end else begin
				nxt.rem = trial[15:0];
				nxt.quo = {in_data.quo[29:0], 1'b0};
			end
		end
		if (DO_ROT) begin
			if (in_data.za >= 0) begin
				nxt.xa = in_data.xa - (in_data.ya >>> IDX);
				nxt.ya = in_data.ya + (in_data.xa >>> IDX);
				nxt.za = in_data.za - STEP;
			end else begin
				nxt.xa = in_data.xa + (in_data.ya >>> IDX);
				nxt.ya = in_data.ya - (in_data.xa >>> IDX);
				nxt.za = in_data.za + STEP;
			end
			if (in_data.zb >= 0) begin
				nxt.xb = in_data.xb - (in_data.yb >>> IDX);
				nxt.yb = in_data.yb + (in_data.xb >>> IDX);
				nxt.zb = in_data.zb - STEP;
			end else begin
				nxt.xb = in_data.xb + (in_data.yb >>> IDX);
				nxt.yb = in_data.yb - (in_data.xb >>> IDX);
				nxt.zb = in_data.zb + STEP;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= nxt;
		end
	end

	assign out_valid = vld_s1;
	assign out_data = data_s1;

endmodule
`default_nettype wire

// ===== hw/rtl/arc_pose_update_unit.sv =====
// Arc pose update unit: propagates a planar pose along an arc or a straight step
//
// Requests enter on the s_ channel (tdata: pos_x, pos_y, heading, step_length,
// heading_change) and leave on the m_ channel (tdata: next_x, next_y,
// next_heading; tuser: saturated). cfg_we writes arc_threshold from cfg_wdata.
// The datapath is one stalling pipeline of 38 register stages: input, prepare,
// 31 stages that each retire one radius quotient bit (the first CORDIC_STAGES of
// them also one CORDIC rotation), then quadrant fix-up, two multiply stages,
// rounding and the output register. A request passes through all of them from
// acceptance to m_tvalid; one request is taken every cycle while the output is
// free or being taken. The 31-bit radius division sets the depth.
// Reset empties the pipeline and sets arc_threshold to 1. When the receiver
// holds m_tready low with a result waiting, the whole pipeline freezes and
// s_tready falls; nothing is lost or repeated, bubbles stay in place.
`default_nettype none
`include "arc_pose_update_unit_assert.svh"
module arc_pose_update_unit #(
	parameter int CORDIC_STAGES = apu_pkg::CORDIC_STAGES_DEF,
	parameter int ANGLE_BITS = apu_pkg::ANGLE_BITS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [9:0]   cfg_wdata,   // arc_threshold
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [119:0] s_tdata,     // pos_x, pos_y, heading, step_length, heading_change
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [79:0]       m_tdata,     // next_x, next_y, next_heading
	output logic              m_tuser      // saturated
);
	import apu_pkg::*;

	localparam int ITER = (DIV_BITS > CORDIC_STAGES) ? DIV_BITS : CORDIC_STAGES;

	logic        en;
	logic [9:0]  thr_q;

	// input decode
	logic signed [31:0] in_px, in_py;
	logic [15:0]        in_hd;
	logic signed [23:0] in_len;
	logic signed [15:0] in_dh;
	logic [15:0]        in_adh;
	logic [23:0]        in_alen;
	logic               in_arc;
	logic [15:0]        in_side, in_nh;

	logic               vld_s1;
	logic signed [31:0] px_s1, py_s1;
	logic signed [23:0] len_s1;
	logic [15:0]        nh_s1, adh_s1, anga_s1, angb_s1;
	logic               arc_s1;
	logic [52:0]        n_s1;

	logic               vld_s2;
	apu_iter_t          data_s2;
	apu_iter_t          s2_nxt;

	logic [ITER:0]      it_v;
	apu_iter_t          it_d [0:ITER];

	apu_iter_t          fin;
	logic signed [CW-1:0] c1, sn1, c2, sn2;
	logic [30:0]        rad;

	logic               vld_s3;
	logic signed [31:0] m_s3, px_s3, py_s3;
	logic signed [34:0] csx_s3, csy_s3;
	logic [15:0]        nh_s3;
	logic               sat_s3, arc_s3;

	logic               vld_s4;
	logic signed [49:0] plox_s4, phix_s4, ploy_s4, phiy_s4;
	logic signed [31:0] px_s4, py_s4;
	logic [15:0]        nh_s4;
	logic               sat_s4;

	logic               vld_s5;
	logic signed [66:0] prx_s5, pry_s5;
	logic signed [31:0] px_s5, py_s5;
	logic [15:0]        nh_s5;
	logic               sat_s5;

	logic               vld_s6;
	logic signed [36:0] rx_s6, ry_s6;
	logic signed [31:0] px_s6, py_s6;
	logic [15:0]        nh_s6;
	logic               sat_s6;

	logic signed [37:0] sumx, sumy;
	logic signed [31:0] nx, ny;
	logic               satx, saty;

	logic               vld_s7;
	logic signed [31:0] nx_s7, ny_s7;
	logic [15:0]        nh_s7;
	logic               sat_s7;

	function automatic logic signed [CW-1:0] rot_c(apu_quad_t q, logic signed [CW-1:0] x,
			logic signed [CW-1:0] y);
		case (q)
			QUAD_0:   return x;
			QUAD_90:  return -y;
			QUAD_180: return -x;
			default:  return y;
		endcase
	endfunction

	function automatic logic signed [CW-1:0] rot_s(apu_quad_t q, logic signed [CW-1:0] x,
			logic signed [CW-1:0] y);
		case (q)
			QUAD_0:   return y;
			QUAD_90:  return x;
			QUAD_180: return -y;
			default:  return -x;
		endcase
	endfunction

	// hold everything while a result waits
	assign en = !vld_s7 || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 10'd1;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	// stage 1: decode, arc decision, radius numerator product
	always_comb begin
		in_px = $signed(s_tdata[31:0]);
		in_py = $signed(s_tdata[63:32]);
		in_hd = s_tdata[79:64];
		in_len = $signed(s_tdata[103:80]);
		in_dh = $signed(s_tdata[119:104]);
		in_adh = in_dh[15] ? 16'(-in_dh) : in_dh;
		in_alen = in_len[23] ? 24'(-in_len) : in_len;
		in_arc = in_adh > {6'd0, thr_q};
		in_side = (in_dh > 0) ? 16'd16384 : 16'd49152;
		in_nh = in_arc ? 16'(in_hd + in_dh) : in_hd;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= in_px;
			py_s1 <= in_py;
			len_s1 <= in_len;
			nh_s1 <= in_nh;
			adh_s1 <= in_adh;
			arc_s1 <= in_arc;
			anga_s1 <= in_arc ? 16'(in_hd + in_side) : in_hd;
			angb_s1 <= 16'(in_nh - in_side);
			n_s1 <= 53'({29'd0, in_alen} * {23'd0, RAD_K});
		end
	end

	// stage 2: overflow check, division start, CORDIC start vectors
	always_comb begin
		s2_nxt.px = px_s1;
		s2_nxt.py = py_s1;
		s2_nxt.len = len_s1;
		s2_nxt.nh = nh_s1;
		s2_nxt.arc = arc_s1;
		s2_nxt.adh = adh_s1;
		s2_nxt.num = n_s1[52:16];
		s2_nxt.rsat = {10'd0, n_s1[52:16]} >= {adh_s1, 31'd0};
		s2_nxt.rem = {10'd0, n_s1[52:47]};
		s2_nxt.quo = '0;
		s2_nxt.qa = quad_of(anga_s1, ANGLE_BITS);
		s2_nxt.qb = quad_of(angb_s1, ANGLE_BITS);
		s2_nxt.xa = INV_GAIN;
		s2_nxt.ya = '0;
		s2_nxt.za = zres_of(anga_s1, ANGLE_BITS);
		s2_nxt.xb = INV_GAIN;
		s2_nxt.yb = '0;
		s2_nxt.zb = zres_of(angb_s1, ANGLE_BITS);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s2 <= s2_nxt;
		end
	end

	assign it_v[0] = vld_s2;
	assign it_d[0] = data_s2;

	for (genvar k = 0; k < ITER; k++) begin : g_iter
		apu_iter_stage #(
			.IDX(k),
			.CORDIC_STAGES(CORDIC_STAGES),
			.ANGLE_BITS(ANGLE_BITS)
		) u_stage (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.in_valid(it_v[k]),
			.in_data(it_d[k]),
			.out_valid(it_v[k+1]),
			.out_data(it_d[k+1])
		);
	end

	// stage 3: quadrant fix-up, pick multiplier operands
	always_comb begin
		fin = it_d[ITER];
		c1 = rot_c(fin.qa, fin.xa, fin.ya);
		sn1 = rot_s(fin.qa, fin.xa, fin.ya);
		c2 = rot_c(fin.qb, fin.xb, fin.yb);
		sn2 = rot_s(fin.qb, fin.xb, fin.yb);
		rad = fin.rsat ? 31'h7FFFFFFF : fin.quo;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s3 <= fin.arc ? $signed({1'b0, rad}) : 32'(fin.len);
			csx_s3 <= fin.arc ? (35'(c1) + 35'(c2)) : 35'(c1);
			csy_s3 <= fin.arc ? (35'(sn1) + 35'(sn2)) : 35'(sn1);
			px_s3 <= fin.px;
			py_s3 <= fin.py;
			nh_s3 <= fin.nh;
			arc_s3 <= fin.arc;
			sat_s3 <= fin.arc & fin.rsat;
		end
	end

	// stage 4: partial products, low half unsigned
	always_ff @(posedge clk) begin
		if (en) begin
			plox_s4 <= m_s3 * $signed({1'b0, csx_s3[16:0]});
			phix_s4 <= m_s3 * $signed(csx_s3[34:17]);
			ploy_s4 <= m_s3 * $signed({1'b0, csy_s3[16:0]});
			phiy_s4 <= m_s3 * $signed(csy_s3[34:17]);
			px_s4 <= px_s3;
			py_s4 <= py_s3;
			nh_s4 <= nh_s3;
			sat_s4 <= sat_s3;
		end
	end

	// stage 5: combine partial products
	always_ff @(posedge clk) begin
		if (en) begin
			prx_s5 <= $signed({phix_s4, 17'd0}) + 67'(plox_s4);
			pry_s5 <= $signed({phiy_s4, 17'd0}) + 67'(ploy_s4);
			px_s5 <= px_s4;
			py_s5 <= py_s4;
			nh_s5 <= nh_s4;
			sat_s5 <= sat_s4;
		end
	end

	// stage 6: round half up out of Q2.30
	always_ff @(posedge clk) begin
		if (en) begin
			rx_s6 <= 37'((prx_s5 + 67'sd536870912) >>> 30);
			ry_s6 <= 37'((pry_s5 + 67'sd536870912) >>> 30);
			px_s6 <= px_s5;
			py_s6 <= py_s5;
			nh_s6 <= nh_s5;
			sat_s6 <= sat_s5;
		end
	end

	// stage 7: add to position and clip
	always_comb begin
		sumx = 38'(px_s6) + 38'(rx_s6);
		sumy = 38'(py_s6) + 38'(ry_s6);
		satx = 1'b1;
		saty = 1'b1;
		if (sumx > 38'sd2147483647) begin
			nx = 32'sh7FFFFFFF;
		end else if (sumx < -38'sd2147483648) begin
			nx = 32'sh80000000;
		end else begin
			nx = sumx[31:0];
			satx = 1'b0;
		end
		if (sumy > 38'sd2147483647) begin
			ny = 32'sh7FFFFFFF;
		end else if (sumy < -38'sd2147483648) begin
			ny = 32'sh80000000;
		end else begin
			ny = sumy[31:0];
			saty = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nx_s7 <= nx;
			ny_s7 <= ny;
			nh_s7 <= nh_s6;
			sat_s7 <= sat_s6 | satx | saty;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= it_v[ITER];
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	assign m_tvalid = vld_s7;
	assign m_tdata = {nh_s7, ny_s7, nx_s7};
	assign m_tuser = sat_s7;

	`APU_ASSERT_NEXT(a_stall_freeze, !en, $stable(it_v) && $stable(vld_s3))
	`APU_ASSERT_NEXT(a_accept_enters, s_tvalid && s_tready, vld_s1)
	`APU_ASSERT_NOW(a_straight_no_rsat, vld_s3 && !arc_s3, !sat_s3)

endmodule
`default_nettype wire
